// ===== rtl/core/line_frame_assembler_queue_top_defines.svh =====
// ----------------------------------------------------------------------------
// Line frame assembler queue - assertion macros
// Shared concurrent assertion forms used by the core modules.
// ----------------------------------------------------------------------------
`ifndef LINE_FRAME_ASSEMBLER_QUEUE_TOP_DEFINES_SVH
`define LINE_FRAME_ASSEMBLER_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LFAQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define LFAQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lfaq_pkg.sv =====
// ----------------------------------------------------------------------------
// Line frame assembler queue - package
// Status codes, byte constants and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfaq_pkg;

    localparam int FLEN_W = 6;
    localparam int CAP_W  = 16;
    localparam int DROP_W = 32;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_CAP   = 2'd2
    } status_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_byte;    // process one received byte
        logic pop_start;    // latch capacity, read head frame length
        logic eval_fail;    // load a single failure/empty result item
        logic fetch_first;  // read byte 0 of head frame
        logic load_byte;    // load fetched byte into the output register
        logic fetch_next;   // read the following byte of head frame
        logic finish;       // last item taken; release head frame if consumed
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic cap_fail;
        logic len_zero;
        logic out_last;
    } dp_stat_t;

endpackage

// ===== rtl/core/lfaq_ram.sv =====
// ----------------------------------------------------------------------------
// Line frame assembler queue - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfaq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lfaq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Line frame assembler queue - controller
// Sequences byte intake and frame pops; drives the channel handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_frame_assembler_queue_top_defines.svh"

module lfaq_ctrl
    import lfaq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_op,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LEN   = 4'b0010,
        S_FETCH = 4'b0100,
        S_SEND  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_op == OP_POP) begin
                        cmd.pop_start = 1'b1;
                        state_next    = S_LEN;
                    end else begin
                        cmd.take_byte = 1'b1;
                    end
                end
            end
            S_LEN: begin
                if (stat.empty || stat.cap_fail || stat.len_zero) begin
                    cmd.eval_fail = 1'b1;
                    state_next    = S_SEND;
                end else begin
                    cmd.fetch_first = 1'b1;
                    state_next      = S_FETCH;
                end
            end
            S_FETCH: begin
                cmd.load_byte = 1'b1;
                state_next    = S_SEND;
            end
            S_SEND: begin
                if (m_ready) begin
                    if (stat.out_last) begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        cmd.fetch_next = 1'b1;
                        state_next     = S_FETCH;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_SEND);

    // Intake and result delivery never overlap
    `LFAQ_ASSERT_IMP(a_no_overlap, aclk, aresetn, s_ready, !m_valid, "input and output both open")

    // A pop request always leads to a length evaluation
    `LFAQ_ASSERT_NXT(a_pop_to_len, aclk, aresetn, cmd.pop_start, state_reg == S_LEN, "pop lost")

endmodule

// ===== rtl/core/lfaq_dp.sv =====
// ----------------------------------------------------------------------------
// Line frame assembler queue - datapath
// Line assembly, slot ring pointers, drop counter, frame memories, output item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_frame_assembler_queue_top_defines.svh"

module lfaq_dp
    import lfaq_pkg::*;
#(
    parameter int FRAME_MAX = 64,
    parameter int SLOTS     = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output dp_stat_t          stat,
    input  logic [7:0]        s_rx_byte,
    input  logic [CAP_W-1:0]  s_capacity,
    output logic [1:0]        m_status,
    output logic [7:0]        m_data_byte,
    output logic [FLEN_W-1:0] m_frame_length,
    output logic              m_last,
    output logic [DROP_W-1:0] m_dropped_count
);

    localparam int LEN_W  = $clog2(FRAME_MAX);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int DEPTH  = SLOTS * FRAME_MAX;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [LEN_W-1:0]  line_len_reg, line_len_next;
    logic              discard_reg, discard_next;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic [DROP_W-1:0] drop_reg, drop_next;

    logic [CAP_W-1:0]  cap_reg;
    logic [LEN_W-1:0]  flen_reg;
    logic [LEN_W-1:0]  idx_reg;

    status_t           out_status_reg;
    logic [7:0]        out_data_reg;
    logic [FLEN_W-1:0] out_len_reg;
    logic              out_last_reg;

    logic [SLOT_W-1:0] wslot_inc, rslot_inc;
    logic              data_we, len_we;
    logic [ADDR_W-1:0] data_waddr, data_raddr;
    logic [LEN_W-1:0]  rd_idx;
    logic [7:0]        data_rdata;
    logic [LEN_W-1:0]  len_rdata;
    logic              is_cr, is_lf;

    // Ring pointer increments
    assign wslot_inc = (wslot_reg == SLOT_W'(SLOTS - 1)) ? '0 : wslot_reg + 1'b1;
    assign rslot_inc = (rslot_reg == SLOT_W'(SLOTS - 1)) ? '0 : rslot_reg + 1'b1;

    assign is_cr = (s_rx_byte == BYTE_CR);
    assign is_lf = (s_rx_byte == BYTE_LF);

    // Line assembly: bytes go straight into the free slot at the write pointer
    always_comb begin
        line_len_next = line_len_reg;
        discard_next  = discard_reg;
        wslot_next    = wslot_reg;
        drop_next     = drop_reg;
        data_we       = 1'b0;
        len_we        = 1'b0;
        if (cmd.take_byte && !is_cr) begin
            if (is_lf) begin
                if (discard_reg) begin
                    discard_next = 1'b0;
                end else if (line_len_reg != '0) begin
                    if (wslot_inc == rslot_reg) begin
                        drop_next = drop_reg + 1'b1;
                    end else begin
                        len_we     = 1'b1;
                        wslot_next = wslot_inc;
                    end
                end
                line_len_next = '0;
            end else if (!discard_reg) begin
                if (line_len_reg == LEN_W'(FRAME_MAX - 1)) begin
                    discard_next  = 1'b1;
                    line_len_next = '0;
                    drop_next     = drop_reg + 1'b1;
                end else begin
                    data_we       = 1'b1;
                    line_len_next = line_len_reg + 1'b1;
                end
            end
        end
        // Release the head frame once fully delivered
        rslot_next = rslot_reg;
        if (cmd.finish && (out_status_reg == STAT_OK)) begin
            rslot_next = rslot_inc;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_len_reg <= '0;
            discard_reg  <= 1'b0;
            wslot_reg    <= '0;
            rslot_reg    <= '0;
            drop_reg     <= '0;
        end else begin
            line_len_reg <= line_len_next;
            discard_reg  <= discard_next;
            wslot_reg    <= wslot_next;
            rslot_reg    <= rslot_next;
            drop_reg     <= drop_next;
        end
    end

    // Memory addressing: slot row times frame size plus byte index
    assign rd_idx     = cmd.fetch_first ? '0 : idx_reg + 1'b1;
    assign data_waddr = ADDR_W'(wslot_reg) * ADDR_W'(FRAME_MAX) + ADDR_W'(line_len_reg);
    assign data_raddr = ADDR_W'(rslot_reg) * ADDR_W'(FRAME_MAX) + ADDR_W'(rd_idx);

    lfaq_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_slot_store (
        .aclk  (aclk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (s_rx_byte),
        .re    (cmd.fetch_first | cmd.fetch_next),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    lfaq_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SLOTS)
    ) u_slot_lengths (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (wslot_reg),
        .wdata (line_len_reg),
        .re    (cmd.pop_start),
        .raddr (rslot_reg),
        .rdata (len_rdata)
    );

    // Pop evaluation flags
    assign stat.empty    = (rslot_reg == wslot_reg);
    assign stat.cap_fail = (cap_reg <= CAP_W'(len_rdata));
    assign stat.len_zero = (len_rdata == '0);
    assign stat.out_last = out_last_reg;

    // Pop payload: capacity, frame length, byte index, output item
    always_ff @(posedge aclk) begin
        if (cmd.pop_start) begin
            cap_reg <= s_capacity;
        end
        if (cmd.fetch_first) begin
            flen_reg <= len_rdata;
            idx_reg  <= '0;
        end else if (cmd.fetch_next) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.eval_fail) begin
            out_data_reg <= '0;
            out_last_reg <= 1'b1;
            priority if (stat.empty) begin
                out_status_reg <= STAT_EMPTY;
                out_len_reg    <= '0;
            end else if (stat.cap_fail) begin
                out_status_reg <= STAT_CAP;
                out_len_reg    <= FLEN_W'(len_rdata);
            end else begin
                out_status_reg <= STAT_OK;
                out_len_reg    <= '0;
            end
        end else if (cmd.load_byte) begin
            out_status_reg <= STAT_OK;
            out_data_reg   <= data_rdata;
            out_len_reg    <= FLEN_W'(flen_reg);
            out_last_reg   <= (idx_reg == flen_reg - 1'b1);
        end
    end

    assign m_status        = out_status_reg;
    assign m_data_byte     = out_data_reg;
    assign m_frame_length  = out_len_reg;
    assign m_last          = out_last_reg;
    assign m_dropped_count = drop_reg;

    // A skipped line holds no collected bytes
    `LFAQ_ASSERT_IMP(a_discard_empty, aclk, aresetn, discard_reg, line_len_reg == '0, "bytes kept while skipping")

    // A delivered frame frees its slot
    `LFAQ_ASSERT_NXT(a_release, aclk, aresetn, cmd.finish && (out_status_reg == STAT_OK), rslot_reg != $past(rslot_reg), "head slot not released")

    // The write pointer never runs onto a queued frame
    `LFAQ_ASSERT_NXT(a_no_overrun, aclk, aresetn, len_we, wslot_reg != rslot_reg, "ring overrun")

endmodule

// ===== rtl/core/line_frame_assembler_queue_top.sv =====
// ----------------------------------------------------------------------------
// Line frame assembler queue - top level
// Newline-delimited frame receiver with a ring of frame slots.
// ----------------------------------------------------------------------------
// Received bytes (op 0) build a line: carriage return is ignored, newline ends
// the line and queues it if non-empty, into a ring of SLOTS slots of FRAME_MAX
// bytes with one slot always kept free; a full ring or a line that grows past
// FRAME_MAX-1 bytes counts a drop, and an overlong line is skipped up to its
// newline. Bytes can be accepted on every cycle while no pop is in progress.
// A pop (op 1) first reads the head frame length from its table, then gives
// one item on a failure, or per frame byte a registered slot memory read and
// then a load of the output register, advancing while m_ready is high. No
// input is taken during a pop. The memories need no clearing after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_frame_assembler_queue_top
    import lfaq_pkg::*;
#(
    parameter int FRAME_MAX = 64,
    parameter int SLOTS     = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [7:0]        s_rx_byte,
    input  logic [CAP_W-1:0]  s_capacity,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [7:0]        m_data_byte,
    output logic [FLEN_W-1:0] m_frame_length,
    output logic              m_last,
    output logic [DROP_W-1:0] m_dropped_count
);

    cmd_t     cmd;
    dp_stat_t stat;

    // Sequencer
    lfaq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Line assembly, frame storage and output item
    lfaq_dp #(
        .FRAME_MAX (FRAME_MAX),
        .SLOTS     (SLOTS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_rx_byte       (s_rx_byte),
        .s_capacity      (s_capacity),
        .m_status        (m_status),
        .m_data_byte     (m_data_byte),
        .m_frame_length  (m_frame_length),
        .m_last          (m_last),
        .m_dropped_count (m_dropped_count)
    );

endmodule
